>>> design/spd_pkg.sv
// Shared types and constants for the speed PID / PWM drive core.
// Used by spd_cfg and speed_pid_pwm_drive_core; depends on nothing else.
`timescale 1ns / 1ps

package spd_pkg;

  // Fixed-point format of speeds, errors and the stored drive level
  localparam int FRAC_BITS = 8;

  // Field widths
  localparam int SPEED_W  = 22;
  localparam int ERR_W    = SPEED_W + 1;
  localparam int DERR_W   = ERR_W + 1;
  localparam int INT_W    = 22;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 21;
  localparam int LEVEL_W  = 16;
  localparam int DRIVE_W  = LEVEL_W + FRAC_BITS;
  localparam int POS_W    = 32;
  localparam int CORR_W   = 32;
  localparam int DIR_W    = 2;

  // Product and sum widths (gain carries a zero sign bit)
  localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_D_W = GAIN_W + 1 + DERR_W;
  localparam int PROD_I_W = GAIN_W + 1 + INT_W;
  localparam int SUM_W    = PROD_D_W + 2;

  // Correction = round(sum / (100 << FRAC_BITS)); 25600 = 25 << 10.
  // |sum| stays below 2^40, so the scaled magnitude fits 31 bits and the
  // quotient 27 bits.
  localparam int DIVISOR     = 100 << FRAC_BITS;
  localparam int ROUND_HALF  = DIVISOR / 2;
  localparam int DIV_SHIFT   = FRAC_BITS + 2;
  localparam int MAG_MSB     = 40;
  localparam int U_W         = MAG_MSB - DIV_SHIFT + 1;
  localparam int RECIP_W     = 32;
  localparam logic [RECIP_W-1:0] RECIP_25 = 32'd2748779070; // ceil(2^36 / 25)
  localparam int RECIP_SHIFT = 36;
  localparam int QPROD_W     = U_W + RECIP_W;
  localparam int Q_W         = QPROD_W - RECIP_SHIFT;

  // Stream packing
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_INT_LIMIT  = 3'd3,
    REG_DRIVE_CEIL = 3'd4,
    REG_CHAN_LIMIT = 3'd5,
    REG_DEADBAND   = 3'd6
  } reg_idx_t;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P     = 16'd256;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I     = 16'd0;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D     = 16'd0;
  localparam logic [LIMIT_W-1:0] RST_INT_LIMIT  = 21'd12800;
  localparam logic [LEVEL_W-1:0] RST_DRIVE_CEIL = 16'd1000;
  localparam logic [LEVEL_W-1:0] RST_CHAN_LIMIT = 16'd1000;
  localparam logic [LEVEL_W-1:0] RST_DEADBAND   = 16'd16;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_CW  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_ACW = 2'd1;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] integral_limit;
    logic [LEVEL_W-1:0] drive_ceiling;
    logic [LEVEL_W-1:0] channel_limit;
    logic [LEVEL_W-1:0] position_deadband;
  } cfg_t;

  // Fields that ride alongside the arithmetic down the pipe
  typedef struct packed {
    logic [DIR_W-1:0] dir;
    logic             zero;
  } side_t;

endpackage

>>> design/spd_cfg.sv
// Configuration register bank with an APB-style slave port.
// Depends on spd_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps

module spd_cfg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [spd_pkg::APB_AW-1:0] paddr,
  input  logic [spd_pkg::APB_DW-1:0] pwdata,
  output logic [spd_pkg::APB_DW-1:0] prdata,
  output logic                     pready,
  output spd_pkg::cfg_t            cfg
);
  import spd_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p            <= RST_GAIN_P;
      cfg_r.gain_i            <= RST_GAIN_I;
      cfg_r.gain_d            <= RST_GAIN_D;
      cfg_r.integral_limit    <= RST_INT_LIMIT;
      cfg_r.drive_ceiling     <= RST_DRIVE_CEIL;
      cfg_r.channel_limit     <= RST_CHAN_LIMIT;
      cfg_r.position_deadband <= RST_DEADBAND;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:     cfg_r.gain_p            <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:     cfg_r.gain_i            <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:     cfg_r.gain_d            <= pwdata[GAIN_W-1:0];
        REG_INT_LIMIT:  cfg_r.integral_limit    <= pwdata[LIMIT_W-1:0];
        REG_DRIVE_CEIL: cfg_r.drive_ceiling     <= pwdata[LEVEL_W-1:0];
        REG_CHAN_LIMIT: cfg_r.channel_limit     <= pwdata[LEVEL_W-1:0];
        REG_DEADBAND:   cfg_r.position_deadband <= pwdata[LEVEL_W-1:0];
        default: ;  // unmapped slot: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:     prdata = APB_DW'(cfg_r.gain_p);
      REG_GAIN_I:     prdata = APB_DW'(cfg_r.gain_i);
      REG_GAIN_D:     prdata = APB_DW'(cfg_r.gain_d);
      REG_INT_LIMIT:  prdata = APB_DW'(cfg_r.integral_limit);
      REG_DRIVE_CEIL: prdata = APB_DW'(cfg_r.drive_ceiling);
      REG_CHAN_LIMIT: prdata = APB_DW'(cfg_r.channel_limit);
      REG_DEADBAND:   prdata = APB_DW'(cfg_r.position_deadband);
      default:        prdata = '0;
    endcase
  end

endmodule

>>> design/speed_pid_pwm_drive_core.sv
// Speed PID controller with accumulated drive level and two-channel compare
// output. Depends on spd_pkg and instantiates spd_cfg.
`timescale 1ns / 1ps
//
//  Channel | Direction | Ports                         | Carries
//  --------+-----------+-------------------------------+------------------------------
//  in      | slave     | in_tvalid/tready/tdata/tuser  | one control tick request
//  out     | master    | out_tvalid/tready/tdata/tuser | one result per tick
//  cfg     | APB slave | cfg_psel .. cfg_pready        | seven control registers
//
//  A request enters every cycle unless out_tready holds the full pipe back;
//  out_tvalid rises once it has passed the input register, five arithmetic
//  stages and the result register. The stage depth is set by the gain
//  multipliers and the reciprocal multiply that divides by 25600. Reset (rst_n
//  low, synchronous) empties the pipe and clears the error, integral and drive
//  state. Each stage advances when the one after it is empty or moving, so
//  bubbles close up and requests keep entering while a result waits on out_tready.

module speed_pid_pwm_drive_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: speed_target[21:0], speed_measured[43:22], direction[45:44],
  //           position_error[77:46], zero pad[79:78]
  // in_tuser: deadband_on[0]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [spd_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,
  // out_tdata: correction[31:0], drive_level[47:32], compare_a[63:48],
  //            compare_b[79:64]
  // out_tuser: channel_clipped[0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [spd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tuser,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [spd_pkg::APB_AW-1:0]       cfg_paddr,
  input  logic [spd_pkg::APB_DW-1:0]       cfg_pwdata,
  output logic [spd_pkg::APB_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready
);
  import spd_pkg::*;

  cfg_t cfg;

  spd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // Stage valids and the ready chain
  // ---------------------------------------------------------------------------
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, vo_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_o;

  assign rdy_o     = !vo_r | out_tready;
  assign rdy5      = !v5_r | rdy_o;
  assign rdy4      = !v4_r | rdy5;
  assign rdy3      = !v3_r | rdy4;
  assign rdy2      = !v2_r | rdy3;
  assign rdy1      = !v1_r | rdy2;
  assign in_tready = !v0_r | rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (in_tready) v0_r <= in_tvalid;
      if (rdy1)      v1_r <= v0_r;
      if (rdy2)      v2_r <= v1_r;
      if (rdy3)      v3_r <= v2_r;
      if (rdy4)      v4_r <= v3_r;
      if (rdy5)      v5_r <= v4_r;
      if (rdy_o)     vo_r <= v5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------------
  logic signed [SPEED_W-1:0] tgt_r, meas_r;
  logic [DIR_W-1:0]          dir0_r;
  logic signed [POS_W-1:0]   perr_r;
  logic                      db_on_r;

  always_ff @(posedge clk) begin
    if (in_tready) begin
      tgt_r   <= in_tdata[SPEED_W-1:0];
      meas_r  <= in_tdata[2*SPEED_W-1:SPEED_W];
      dir0_r  <= in_tdata[2*SPEED_W+DIR_W-1:2*SPEED_W];
      perr_r  <= in_tdata[2*SPEED_W+DIR_W+POS_W-1:2*SPEED_W+DIR_W];
      db_on_r <= in_tuser;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: error, error difference, clamped integral, deadband test.
  // The error history and integral update here, so back-to-back ticks see
  // the previous tick's values.
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0]  prev_err_r, err_nxt;
  logic signed [INT_W-1:0]  integ_r, integ_nxt;
  logic signed [DERR_W-1:0] derr_nxt;
  logic signed [DERR_W-1:0] isum, lim_s;
  logic [POS_W-1:0]         pmag;
  side_t                    side_nxt;

  logic signed [ERR_W-1:0]  err1_r;
  logic signed [DERR_W-1:0] derr1_r;
  logic signed [INT_W-1:0]  integ1_r;
  side_t                    side1_r;

  always_comb begin
    err_nxt  = ERR_W'(tgt_r) - ERR_W'(meas_r);
    derr_nxt = DERR_W'(err_nxt) - DERR_W'(prev_err_r);
    isum     = DERR_W'(integ_r) + DERR_W'(err_nxt);
    lim_s    = $signed({{(DERR_W-LIMIT_W){1'b0}}, cfg.integral_limit});
    if (isum > lim_s) begin
      integ_nxt = lim_s[INT_W-1:0];
    end else if (isum < -lim_s) begin
      integ_nxt = INT_W'(-lim_s);
    end else begin
      integ_nxt = isum[INT_W-1:0];
    end
    // magnitude as unsigned, so the most negative value reads as 2^31
    pmag          = perr_r[POS_W-1] ? (~perr_r + 1'b1) : perr_r;
    side_nxt.dir  = dir0_r;
    side_nxt.zero = db_on_r && (pmag < {{(POS_W-LEVEL_W){1'b0}}, cfg.position_deadband});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      integ_r    <= '0;
    end else if (rdy1 && v0_r) begin
      prev_err_r <= err_nxt;
      integ_r    <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      err1_r   <= err_nxt;
      derr1_r  <= derr_nxt;
      integ1_r <= integ_nxt;
      side1_r  <= side_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: gain products, one multiplier per term
  // ---------------------------------------------------------------------------
  logic signed [PROD_P_W-1:0] prod_p_r;
  logic signed [PROD_D_W-1:0] prod_d_r;
  logic signed [PROD_I_W-1:0] prod_i_r;
  side_t                      side2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      prod_p_r <= $signed({1'b0, cfg.gain_p}) * err1_r;
      prod_d_r <= $signed({1'b0, cfg.gain_d}) * derr1_r;
      prod_i_r <= $signed({1'b0, cfg.gain_i}) * integ1_r;
      side2_r  <= side1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: PID sum
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum3_r;
  side_t                   side3_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      sum3_r  <= SUM_W'(prod_p_r) + SUM_W'(prod_d_r) + SUM_W'(prod_i_r);
      side3_r <= side2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: magnitude plus half the divisor, then drop the power-of-two part
  // of the divisor. Rounding is to nearest, ties away from zero.
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] rnd;
  logic [U_W-1:0]          u4_r;
  logic                    neg4_r;
  side_t                   side4_r;

  assign rnd = sum3_r[SUM_W-1] ? (SUM_W'(ROUND_HALF) - sum3_r)
                               : (sum3_r + SUM_W'(ROUND_HALF));

  always_ff @(posedge clk) begin
    if (rdy4) begin
      u4_r    <= rnd[MAG_MSB:DIV_SHIFT];
      neg4_r  <= sum3_r[SUM_W-1];
      side4_r <= side3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: divide by 25 through the reciprocal, exact for this input range
  // ---------------------------------------------------------------------------
  logic [QPROD_W-1:0] qprod;
  logic [Q_W-1:0]     q5_r;
  logic               neg5_r;
  side_t              side5_r;

  assign qprod = QPROD_W'(u4_r) * QPROD_W'(RECIP_25);

  always_ff @(posedge clk) begin
    if (rdy5) begin
      q5_r    <= qprod[QPROD_W-1:RECIP_SHIFT];
      neg5_r  <= neg4_r;
      side5_r <= side4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: accumulate drive, clamp, deadband, channel steering.
  // The stored drive updates here, one tick at a time in pipe order.
  // ---------------------------------------------------------------------------
  localparam int DSUM_W = Q_W + 2;

  logic [DRIVE_W-1:0]       last_drive_r, drive_nxt;
  logic signed [Q_W:0]      corr;
  logic signed [DSUM_W-1:0] dsum, ceil_s;
  logic [DRIVE_W-1:0]       ceil_fx;
  logic [LEVEL_W-1:0]       level, cmp, ca, cb;
  logic                     clip;

  logic [CORR_W-1:0]  corr_o_r;
  logic [LEVEL_W-1:0] level_o_r, ca_o_r, cb_o_r;
  logic               clip_o_r;

  always_comb begin
    corr    = neg5_r ? -$signed({1'b0, q5_r}) : $signed({1'b0, q5_r});
    ceil_fx = {cfg.drive_ceiling, {FRAC_BITS{1'b0}}};
    ceil_s  = $signed({{(DSUM_W-DRIVE_W){1'b0}}, ceil_fx});
    dsum    = $signed({{(DSUM_W-DRIVE_W){1'b0}}, last_drive_r}) + DSUM_W'(corr);
    if (dsum[DSUM_W-1]) begin
      drive_nxt = '0;
    end else if (dsum > ceil_s) begin
      drive_nxt = ceil_fx;
    end else begin
      drive_nxt = dsum[DRIVE_W-1:0];
    end
    if (side5_r.zero) drive_nxt = '0;

    level = drive_nxt[DRIVE_W-1:FRAC_BITS];
    clip  = level >= cfg.channel_limit;
    cmp   = clip ? cfg.channel_limit : level;
    ca    = '0;
    cb    = '0;
    case (side5_r.dir)
      DIR_CW:  cb = cmp;
      DIR_ACW: ca = cmp;
      default: clip = 1'b0;  // stop or unused code: both channels off
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_drive_r <= '0;
    end else if (rdy_o && v5_r) begin
      last_drive_r <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      corr_o_r  <= CORR_W'(corr);
      level_o_r <= level;
      ca_o_r    <= ca;
      cb_o_r    <= cb;
      clip_o_r  <= clip;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {cb_o_r, ca_o_r, level_o_r, corr_o_r};
  assign out_tuser  = clip_o_r;

endmodule
